[rtl/ffsa_pkg.sv]
// Shared types and constants for the first-fit segment allocator.
// Used by ffsa_cell and first_fit_segment_allocator; depends on nothing.
package ffsa_pkg;

    // Default sizing
    localparam longint unsigned HEAP_BYTES_DEF = 64'd65536;
    localparam int              MAX_SEG_DEF    = 64;

    // Port field widths
    localparam int REQ_SIZE_W  = 17;
    localparam int FREE_OFS_W  = 16;
    localparam int STATUS_W    = 3;
    localparam int ALLOC_OFS_W = 16;
    localparam int S_TDATA_W   = 40;   // 17 + 16 = 33, padded to bytes
    localparam int M_TDATA_W   = 24;   // 3 + 16 = 19, padded to bytes

    // Request kind
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_NO_FIT    = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_ZERO      = 3'd4
    } t_status;

    // Command broadcast to every cell of the table chain
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ROTATE,   // every cell takes its right neighbor, tail takes head
        CELL_WRITE,    // selected cell loads write data
        CELL_INSERT,   // cells above selected take left neighbor, selected loads
        CELL_DELETE    // selected cell and above take right neighbor
    } t_cell_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_EXEC,
        ST_RESP
    } t_state;

endpackage

[rtl/ffsa_cell.sv]
// One entry of the segment table: begin, length, used and valid flags.
// Shifts with its neighbors on broadcast commands; uses ffsa_pkg.
module ffsa_cell #(
    parameter longint unsigned HEAP_BYTES   = ffsa_pkg::HEAP_BYTES_DEF,
    parameter int              MAX_SEGMENTS = ffsa_pkg::MAX_SEG_DEF,
    parameter int              CELL_IDX     = 0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ffsa_pkg::t_cell_op                  i_op,
    input  logic [$clog2(MAX_SEGMENTS)-1:0]     i_sel_idx,
    input  logic [$clog2(HEAP_BYTES)-1:0]       i_wr_begin,
    input  logic [$clog2(HEAP_BYTES+1)-1:0]     i_wr_len,
    input  logic                                i_wr_used,
    input  logic [$clog2(HEAP_BYTES)-1:0]       i_left_begin,
    input  logic [$clog2(HEAP_BYTES+1)-1:0]     i_left_len,
    input  logic                                i_left_used,
    input  logic                                i_left_valid,
    input  logic [$clog2(HEAP_BYTES)-1:0]       i_right_begin,
    input  logic [$clog2(HEAP_BYTES+1)-1:0]     i_right_len,
    input  logic                                i_right_used,
    input  logic                                i_right_valid,
    output logic [$clog2(HEAP_BYTES)-1:0]       o_begin,
    output logic [$clog2(HEAP_BYTES+1)-1:0]     o_len,
    output logic                                o_used,
    output logic                                o_valid
);

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int OFS_W = $clog2(HEAP_BYTES);
    localparam int LEN_W = $clog2(HEAP_BYTES+1);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [OFS_W-1:0] r_begin, n_begin;
    logic [LEN_W-1:0] r_len,   n_len;
    logic             r_used,  n_used;
    logic             r_valid, n_valid;

    always_comb begin
        n_begin = r_begin;
        n_len   = r_len;
        n_used  = r_used;
        n_valid = r_valid;
        case (i_op)
            ffsa_pkg::CELL_ROTATE: begin
                n_begin = i_right_begin;
                n_len   = i_right_len;
                n_used  = i_right_used;
                n_valid = i_right_valid;
            end
            ffsa_pkg::CELL_WRITE: begin
                if (MY_IDX == i_sel_idx) begin
                    n_begin = i_wr_begin;
                    n_len   = i_wr_len;
                    n_used  = i_wr_used;
                    n_valid = 1'b1;
                end
            end
            ffsa_pkg::CELL_INSERT: begin
                if (MY_IDX > i_sel_idx) begin
                    n_begin = i_left_begin;
                    n_len   = i_left_len;
                    n_used  = i_left_used;
                    n_valid = i_left_valid;
                end else if (MY_IDX == i_sel_idx) begin
                    n_begin = i_wr_begin;
                    n_len   = i_wr_len;
                    n_used  = i_wr_used;
                    n_valid = 1'b1;
                end
            end
            ffsa_pkg::CELL_DELETE: begin
                if (MY_IDX >= i_sel_idx) begin
                    n_begin = i_right_begin;
                    n_len   = i_right_len;
                    n_used  = i_right_used;
                    n_valid = i_right_valid;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // entry zero spans the whole heap, the rest are empty
            r_begin <= '0;
            r_len   <= (CELL_IDX == 0) ? LEN_W'(HEAP_BYTES) : '0;
            r_used  <= 1'b0;
            r_valid <= (CELL_IDX == 0);
        end else begin
            r_begin <= n_begin;
            r_len   <= n_len;
            r_used  <= n_used;
            r_valid <= n_valid;
        end
    end

    assign o_begin = r_begin;
    assign o_len   = r_len;
    assign o_used  = r_used;
    assign o_valid = r_valid;

endmodule

[rtl/first_fit_segment_allocator.sv]
// First-fit segment allocator with coalescing: controller plus a chain of table cells.
// Depends on ffsa_pkg and ffsa_cell.
//
//  channel   | dir | tdata (low bit up)                     | tuser
//  ----------+-----+----------------------------------------+-----------
//  s_axis    | in  | req_size[16:0], free_offset[32:17]     | kind[0]
//  m_axis    | out | status_code[2:0], alloc_offset[18:3]   | -
//
// Flow: a zero-size allocate goes from acceptance straight to the response
// state; any other word scans the table and decides, then a refused word (no
// fit, table full, offset not found) goes to the response state, and a word
// that edits the table runs its edit steps first. The next word is taken in
// the cycle after the load. The table scan rotates the whole cell chain once
// past the head cell, one entry per cycle; then a decide step, and for an edit
// one to three write/insert/delete steps edit the chain.
// Reset: synchronous, active low; the table holds one free segment over the
// whole heap right after reset, no clearing pass.
// Stalls: the result sits in an output register; the next word is accepted
// while it waits, and a new result only stalls if the old one is still held.
module first_fit_segment_allocator #(
    parameter longint unsigned HEAP_BYTES   = ffsa_pkg::HEAP_BYTES_DEF,
    parameter int              MAX_SEGMENTS = ffsa_pkg::MAX_SEG_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [16:0] req_size, [32:17] free_offset, [39:33] zero
    input  logic [ffsa_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // [0] kind
    input  logic [0:0]                         i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [2:0] status_code, [18:3] alloc_offset, [23:19] zero
    output logic [ffsa_pkg::M_TDATA_W-1:0]     o_m_axis_tdata
);

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS+1);
    localparam int OFS_W = $clog2(HEAP_BYTES);
    localparam int LEN_W = $clog2(HEAP_BYTES+1);
    // compare widths: table fields against the request fields
    localparam int LC_W  = (LEN_W > ffsa_pkg::REQ_SIZE_W) ? LEN_W : ffsa_pkg::REQ_SIZE_W;
    localparam int OC_W  = (OFS_W > ffsa_pkg::ALLOC_OFS_W) ? OFS_W : ffsa_pkg::ALLOC_OFS_W;
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(MAX_SEGMENTS-1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_SEGMENTS);

    // ---------------- cell chain ----------------
    logic [OFS_W-1:0] w_begin [MAX_SEGMENTS];
    logic [LEN_W-1:0] w_len   [MAX_SEGMENTS];
    logic             w_used  [MAX_SEGMENTS];
    logic             w_valid [MAX_SEGMENTS];

    ffsa_pkg::t_cell_op cell_op;
    logic [IDX_W-1:0]   sel_idx;
    logic [OFS_W-1:0]   wr_begin;
    logic [LEN_W-1:0]   wr_len;
    logic               wr_used;

    // tail input: head entry on rotate, an empty entry on delete
    logic             rotating;
    logic [OFS_W-1:0] tail_begin;
    logic [LEN_W-1:0] tail_len;
    logic             tail_used;
    logic             tail_valid;

    assign rotating   = (cell_op == ffsa_pkg::CELL_ROTATE);
    assign tail_begin = rotating ? w_begin[0] : '0;
    assign tail_len   = rotating ? w_len[0]   : '0;
    assign tail_used  = rotating && w_used[0];
    assign tail_valid = rotating && w_valid[0];

    for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
        logic [OFS_W-1:0] l_begin, rt_begin;
        logic [LEN_W-1:0] l_len,   rt_len;
        logic             l_used,  rt_used;
        logic             l_valid, rt_valid;

        if (g == 0) begin : g_head
            assign l_begin = '0;
            assign l_len   = '0;
            assign l_used  = 1'b0;
            assign l_valid = 1'b0;
        end else begin : g_mid
            assign l_begin = w_begin[g-1];
            assign l_len   = w_len[g-1];
            assign l_used  = w_used[g-1];
            assign l_valid = w_valid[g-1];
        end

        if (g == MAX_SEGMENTS-1) begin : g_tail
            assign rt_begin = tail_begin;
            assign rt_len   = tail_len;
            assign rt_used  = tail_used;
            assign rt_valid = tail_valid;
        end else begin : g_body
            assign rt_begin = w_begin[g+1];
            assign rt_len   = w_len[g+1];
            assign rt_used  = w_used[g+1];
            assign rt_valid = w_valid[g+1];
        end

        ffsa_cell #(
            .HEAP_BYTES  (HEAP_BYTES),
            .MAX_SEGMENTS(MAX_SEGMENTS),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (cell_op),
            .i_sel_idx    (sel_idx),
            .i_wr_begin   (wr_begin),
            .i_wr_len     (wr_len),
            .i_wr_used    (wr_used),
            .i_left_begin (l_begin),
            .i_left_len   (l_len),
            .i_left_used  (l_used),
            .i_left_valid (l_valid),
            .i_right_begin(rt_begin),
            .i_right_len  (rt_len),
            .i_right_used (rt_used),
            .i_right_valid(rt_valid),
            .o_begin      (w_begin[g]),
            .o_len        (w_len[g]),
            .o_used       (w_used[g]),
            .o_valid      (w_valid[g])
        );
    end

    // ---------------- controller state ----------------
    ffsa_pkg::t_state  r_state, n_state;
    logic [IDX_W-1:0]  r_pos;         // table index currently at the head cell
    logic [CNT_W-1:0]  r_count;       // valid entries
    logic              r_found;
    logic              r_need_next;   // grab the entry after the hit on the next cycle
    logic [1:0]        r_step;        // edit step within ST_EXEC
    logic              r_out_valid;

    // request and scan captures (no reset needed)
    logic                               r_kind;
    logic [ffsa_pkg::REQ_SIZE_W-1:0]    r_size;
    logic [ffsa_pkg::FREE_OFS_W-1:0]    r_ofs;
    logic [IDX_W-1:0]                   r_hit_idx;
    logic [OFS_W-1:0]                   r_hit_begin;
    logic [LEN_W-1:0]                   r_hit_len;
    logic [OFS_W-1:0]                   r_prev_begin;
    logic [LEN_W-1:0]                   r_prev_len;
    logic                               r_prev_used;
    logic                               r_next_valid;
    logic                               r_next_used;
    logic [LEN_W-1:0]                   r_next_len;
    ffsa_pkg::t_status                  r_status;
    ffsa_pkg::t_status                  r_out_status;
    logic [ffsa_pkg::ALLOC_OFS_W-1:0]   r_out_ofs;

    logic s_accept, out_load, zero_req;
    logic [ffsa_pkg::REQ_SIZE_W-1:0] in_size;

    assign in_size  = i_s_axis_tdata[ffsa_pkg::REQ_SIZE_W-1:0];
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign zero_req = (i_s_axis_tuser[0] == ffsa_pkg::KIND_ALLOC) && (in_size == '0);
    assign out_load = (r_state == ffsa_pkg::ST_RESP) && (!r_out_valid || i_m_axis_tready);

    // ---------------- head-cell match ----------------
    logic [LC_W-1:0] size_c;
    logic            alloc_hit, free_hit, scan_hit;

    assign size_c    = LC_W'(r_size);
    assign alloc_hit = w_valid[0] && !w_used[0] && (LC_W'(w_len[0]) >= size_c);
    assign free_hit  = w_valid[0] && (OC_W'(w_begin[0]) == OC_W'(r_ofs));
    assign scan_hit  = (r_kind == ffsa_pkg::KIND_FREE) ? free_hit : alloc_hit;

    // ---------------- outcome ----------------
    logic              exact;
    ffsa_pkg::t_status dec_status;

    assign exact = (LC_W'(r_hit_len) == size_c);

    always_comb begin
        if (r_kind == ffsa_pkg::KIND_FREE) begin
            dec_status = r_found ? ffsa_pkg::STAT_OK : ffsa_pkg::STAT_NOT_FOUND;
        end else if (!r_found) begin
            dec_status = ffsa_pkg::STAT_NO_FIT;
        end else if (!exact && (r_count == FULL_CNT)) begin
            dec_status = ffsa_pkg::STAT_FULL;
        end else begin
            dec_status = ffsa_pkg::STAT_OK;
        end
    end

    // ---------------- edit plan ----------------
    // alloc: write hit (used), then insert remainder behind it on a split
    // free:  merge into previous and/or swallow next, deleting merged entries; else just mark the hit free
    logic             prev_free, next_free, plan_last;
    logic [IDX_W-1:0] idx_m1, idx_p1;
    logic [LEN_W-1:0] sum_ph, sum_all, sum_hn;
    ffsa_pkg::t_cell_op plan_op;

    assign prev_free = (r_hit_idx != '0) && !r_prev_used;
    assign next_free = r_next_valid && !r_next_used;
    assign idx_m1    = r_hit_idx - 1'b1;
    assign idx_p1    = r_hit_idx + 1'b1;
    assign sum_ph    = r_prev_len + r_hit_len;
    assign sum_all   = sum_ph + r_next_len;
    assign sum_hn    = r_hit_len + r_next_len;

    always_comb begin
        plan_op   = ffsa_pkg::CELL_HOLD;
        plan_last = 1'b1;
        sel_idx   = r_hit_idx;
        wr_begin  = r_hit_begin;
        wr_len    = r_hit_len;
        wr_used   = 1'b0;
        if (r_kind == ffsa_pkg::KIND_ALLOC) begin
            if (r_step == 2'd0) begin
                plan_op   = ffsa_pkg::CELL_WRITE;
                wr_len    = exact ? r_hit_len : LEN_W'(r_size);
                wr_used   = 1'b1;
                plan_last = exact;
            end else begin
                plan_op  = ffsa_pkg::CELL_INSERT;
                sel_idx  = idx_p1;
                wr_begin = r_hit_begin + OFS_W'(r_size);
                wr_len   = r_hit_len - LEN_W'(r_size);
            end
        end else if (prev_free) begin
            case (r_step)
                2'd0: begin
                    plan_op   = ffsa_pkg::CELL_WRITE;
                    sel_idx   = idx_m1;
                    wr_begin  = r_prev_begin;
                    wr_len    = next_free ? sum_all : sum_ph;
                    plan_last = 1'b0;
                end
                2'd1: begin
                    plan_op   = ffsa_pkg::CELL_DELETE;
                    plan_last = !next_free;
                end
                default: begin
                    // old next entry has slid down into the hit slot
                    plan_op = ffsa_pkg::CELL_DELETE;
                end
            endcase
        end else if (next_free) begin
            if (r_step == 2'd0) begin
                plan_op   = ffsa_pkg::CELL_WRITE;
                wr_len    = sum_hn;
                plan_last = 1'b0;
            end else begin
                plan_op = ffsa_pkg::CELL_DELETE;
                sel_idx = idx_p1;
            end
        end else begin
            plan_op = ffsa_pkg::CELL_WRITE;
        end
    end

    // ---------------- state machine ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffsa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        cell_op         = ffsa_pkg::CELL_HOLD;
        o_s_axis_tready = 1'b0;
        case (r_state)
            ffsa_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_state = zero_req ? ffsa_pkg::ST_RESP : ffsa_pkg::ST_SCAN;
                end
            end
            ffsa_pkg::ST_SCAN: begin
                cell_op = ffsa_pkg::CELL_ROTATE;
                if (r_pos == LAST_POS) begin
                    n_state = ffsa_pkg::ST_DECIDE;
                end
            end
            ffsa_pkg::ST_DECIDE: begin
                n_state = (dec_status == ffsa_pkg::STAT_OK) ? ffsa_pkg::ST_EXEC
                                                            : ffsa_pkg::ST_RESP;
            end
            ffsa_pkg::ST_EXEC: begin
                cell_op = plan_op;
                if (plan_last) begin
                    n_state = ffsa_pkg::ST_RESP;
                end
            end
            ffsa_pkg::ST_RESP: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state = ffsa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ffsa_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_count     <= CNT_W'(1);
            r_found     <= 1'b0;
            r_need_next <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_pos       <= '0;
                r_found     <= 1'b0;
                r_need_next <= 1'b0;
                r_step      <= '0;
            end
            if (r_state == ffsa_pkg::ST_SCAN) begin
                r_pos <= r_pos + 1'b1;
                if (!r_found && scan_hit) begin
                    r_found     <= 1'b1;
                    r_need_next <= 1'b1;
                end else begin
                    r_need_next <= 1'b0;
                end
            end
            if (r_state == ffsa_pkg::ST_EXEC) begin
                r_step <= r_step + 1'b1;
            end
            if (cell_op == ffsa_pkg::CELL_INSERT) begin
                r_count <= r_count + 1'b1;
            end else if (cell_op == ffsa_pkg::CELL_DELETE) begin
                r_count <= r_count - 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- request / capture registers ----------------
    logic [OC_W-1:0] hit_begin_x;
    assign hit_begin_x = OC_W'(r_hit_begin);

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_kind       <= i_s_axis_tuser[0];
            r_size       <= in_size;
            r_ofs        <= i_s_axis_tdata[ffsa_pkg::REQ_SIZE_W +: ffsa_pkg::FREE_OFS_W];
            r_next_valid <= 1'b0;
            r_status     <= ffsa_pkg::STAT_ZERO;
        end
        if (r_state == ffsa_pkg::ST_SCAN) begin
            if (!r_found && scan_hit) begin
                r_hit_idx   <= r_pos;
                r_hit_begin <= w_begin[0];
                r_hit_len   <= w_len[0];
            end else if (!r_found) begin
                // entry just ahead of a later hit
                r_prev_begin <= w_begin[0];
                r_prev_len   <= w_len[0];
                r_prev_used  <= w_used[0];
            end
            if (r_need_next) begin
                r_next_valid <= w_valid[0];
                r_next_used  <= w_used[0];
                r_next_len   <= w_len[0];
            end
        end
        if (r_state == ffsa_pkg::ST_DECIDE) begin
            r_status <= dec_status;
        end
        if (out_load) begin
            r_out_status <= r_status;
            r_out_ofs    <= ((r_kind == ffsa_pkg::KIND_ALLOC) &&
                             (r_status == ffsa_pkg::STAT_OK))
                            ? hit_begin_x[ffsa_pkg::ALLOC_OFS_W-1:0] : '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(ffsa_pkg::M_TDATA_W - ffsa_pkg::STATUS_W
                                - ffsa_pkg::ALLOC_OFS_W){1'b0}},
                              r_out_ofs, r_out_status};

    // ---------------- assertions ----------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= FULL_CNT))
        else $error("segment count out of range");

    // a full rotation must bring entry zero back to the head
    a_head_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffsa_pkg::ST_IDLE) |-> (w_valid[0] && (w_begin[0] == '0)))
        else $error("table not back in place after scan");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cell_op == ffsa_pkg::CELL_INSERT) |-> (r_count < FULL_CNT))
        else $error("insert into a full table");

    a_delete_keeps_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cell_op == ffsa_pkg::CELL_DELETE) |-> (r_count > CNT_W'(1)))
        else $error("delete would empty the table");

endmodule
